[rtl/fsge_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsge_pkg: shared types and codes for the four-state gate evaluator
// Six-valued logic codes, gate kinds, stream widths and the decoded item.
// ---------------------------------------------------------------------------
package fsge_pkg;

    // Number of gate input fields carried by one item
    localparam int FIELD_LANES     = 8;
    // Default reduction width for the and/or family
    localparam int INPUT_LANES_DEF = 8;

    // Field widths
    localparam int KIND_W  = 4;
    localparam int COUNT_W = 4;
    localparam int VAL_W   = 3;

    // Stream data widths (whole bytes)
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    typedef logic [VAL_W-1:0]   t_val;
    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [COUNT_W-1:0] t_count;

    // Six-valued logic codes
    localparam t_val V_0 = 3'd0;
    localparam t_val V_1 = 3'd1;
    localparam t_val V_X = 3'd2;
    localparam t_val V_Z = 3'd3;
    localparam t_val V_L = 3'd4;
    localparam t_val V_H = 3'd5;

    // Gate kinds
    localparam t_kind K_NOT    = 4'd0;
    localparam t_kind K_BUF    = 4'd1;
    localparam t_kind K_AND    = 4'd2;
    localparam t_kind K_OR     = 4'd3;
    localparam t_kind K_XOR    = 4'd4;
    localparam t_kind K_NAND   = 4'd5;
    localparam t_kind K_NOR    = 4'd6;
    localparam t_kind K_XNOR   = 4'd7;
    localparam t_kind K_BUFIF0 = 4'd8;
    localparam t_kind K_BUFIF1 = 4'd9;
    localparam t_kind K_NOTIF0 = 4'd10;
    localparam t_kind K_NOTIF1 = 4'd11;
    localparam t_kind K_ASSIGN = 4'd12;

    // One decoded gate item
    typedef struct packed {
        t_kind                      kind;
        t_count                     input_count;
        logic [FIELD_LANES-1:0][VAL_W-1:0] vals;
    } t_item;

endpackage

[rtl/fsge_in_stage.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsge_in_stage: input register of the gate evaluator
// Captures one gate item per transfer and holds it until the next stage
// takes it; a new transfer is taken in the same cycle as the hand-over.
// ---------------------------------------------------------------------------
module fsge_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: kind[3:0], input_count[7:4], in0[10:8], in1[13:11], in2[16:14],
    //        in3[19:17], in4[22:20], in5[25:23], in6[28:26], in7[31:29]
    input  logic [fsge_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                          i_advance,
    output logic                          o_valid,
    output fsge_pkg::t_item               o_item
);

    logic            r_valid;
    logic            n_valid;
    fsge_pkg::t_item r_item;
    logic            w_take;

    // Accept while empty or while the held item moves on
    assign o_s_axis_tready = !r_valid || i_advance;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    // Hold or refill the valid flag
    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Unpack the transfer into the item fields
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.kind        <= i_s_axis_tdata[3:0];
            r_item.input_count <= i_s_axis_tdata[7:4];
            for (int i = 0; i < fsge_pkg::FIELD_LANES; i++) begin
                r_item.vals[i] <= i_s_axis_tdata[8 + fsge_pkg::VAL_W*i +: fsge_pkg::VAL_W];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/fsge_eval.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsge_eval: six-valued primitive gate evaluation
// Combinational evaluation of one gate item: not, buf, the and/or family
// over the first input_count lanes, xor/xnor, the tristate gates and assign.
// ---------------------------------------------------------------------------
module fsge_eval #(
    parameter int INPUT_LANES = fsge_pkg::INPUT_LANES_DEF
) (
    input  fsge_pkg::t_item i_item,
    output fsge_pkg::t_val  o_gate_value
);

    // Reduction width never exceeds the carried fields
    localparam int LANES_EFF = (INPUT_LANES < fsge_pkg::FIELD_LANES) ?
                               INPUT_LANES : fsge_pkg::FIELD_LANES;
    localparam fsge_pkg::t_count LANES_CNT = fsge_pkg::COUNT_W'(LANES_EFF);

    // Undefined codes read as X
    function automatic fsge_pkg::t_val norm_val(input fsge_pkg::t_val v);
        return (v > fsge_pkg::V_H) ? fsge_pkg::V_X : v;
    endfunction

    function automatic logic is_xz(input fsge_pkg::t_val v);
        return (v == fsge_pkg::V_X) || (v == fsge_pkg::V_Z);
    endfunction

    // Invert a reduction result unless it is X
    function automatic fsge_pkg::t_val invert_known(input fsge_pkg::t_val r);
        fsge_pkg::t_val res;
        if (r == fsge_pkg::V_X) begin
            res = fsge_pkg::V_X;
        end else if (r == fsge_pkg::V_0) begin
            res = fsge_pkg::V_1;
        end else begin
            res = fsge_pkg::V_0;
        end
        return res;
    endfunction

    // Tristate driver: on fully enables, off gives Z, anything else weakens a 0 or 1 data input
    function automatic fsge_pkg::t_val eval_tri(
        input fsge_pkg::t_val data,
        input fsge_pkg::t_val ctl,
        input fsge_pkg::t_val on,
        input fsge_pkg::t_val off,
        input logic           inv
    );
        fsge_pkg::t_val res;
        if (ctl == off) begin
            res = fsge_pkg::V_Z;
        end else if (is_xz(data)) begin
            res = fsge_pkg::V_X;
        end else if (ctl != on && data == fsge_pkg::V_0) begin
            res = inv ? fsge_pkg::V_H : fsge_pkg::V_L;
        end else if (ctl != on && data == fsge_pkg::V_1) begin
            res = inv ? fsge_pkg::V_L : fsge_pkg::V_H;
        end else if (!inv) begin
            res = data;
        end else if (data == fsge_pkg::V_0 || data == fsge_pkg::V_L) begin
            res = fsge_pkg::V_1;
        end else if (data == fsge_pkg::V_1 || data == fsge_pkg::V_H) begin
            res = fsge_pkg::V_0;
        end else begin
            res = fsge_pkg::V_X;
        end
        return res;
    endfunction

    fsge_pkg::t_val [fsge_pkg::FIELD_LANES-1:0] w_v;
    fsge_pkg::t_count                           w_n;
    logic [fsge_pkg::FIELD_LANES-1:0]           w_used;
    logic                                       w_any0;
    logic                                       w_any1;
    logic                                       w_anyxz;
    fsge_pkg::t_val                             w_and;
    fsge_pkg::t_val                             w_or;
    fsge_pkg::t_val                             w_a;
    fsge_pkg::t_val                             w_b;
    logic                                       w_ab_xz;
    fsge_pkg::t_val                             w_xor;
    fsge_pkg::t_val                             w_xnor;

    // Normalise lanes and clamp the input count
    always_comb begin
        for (int i = 0; i < fsge_pkg::FIELD_LANES; i++) begin
            w_v[i] = norm_val(i_item.vals[i]);
        end
        w_n = i_item.input_count;
        if (w_n == '0) begin
            w_n = fsge_pkg::COUNT_W'(1);
        end
        if (w_n > LANES_CNT) begin
            w_n = LANES_CNT;
        end
    end

    // Flag the lanes in use and reduce over them
    always_comb begin
        w_any0  = 1'b0;
        w_any1  = 1'b0;
        w_anyxz = 1'b0;
        for (int i = 0; i < fsge_pkg::FIELD_LANES; i++) begin
            w_used[i] = fsge_pkg::COUNT_W'(i) < w_n;
            w_any0    = w_any0  | (w_used[i] & (w_v[i] == fsge_pkg::V_0));
            w_any1    = w_any1  | (w_used[i] & (w_v[i] == fsge_pkg::V_1));
            w_anyxz   = w_anyxz | (w_used[i] & is_xz(w_v[i]));
        end
        w_and = w_any0 ? fsge_pkg::V_0 : (w_anyxz ? fsge_pkg::V_X : fsge_pkg::V_1);
        w_or  = w_any1 ? fsge_pkg::V_1 : (w_anyxz ? fsge_pkg::V_X : fsge_pkg::V_0);
    end

    // Two-input xor and xnor on lanes 0 and 1
    assign w_a     = w_v[0];
    assign w_b     = w_v[1];
    assign w_ab_xz = is_xz(w_a) || is_xz(w_b);
    assign w_xor   = w_ab_xz ? fsge_pkg::V_X :
                     (((w_a == fsge_pkg::V_1 && w_b == fsge_pkg::V_0) ||
                       (w_a == fsge_pkg::V_0 && w_b == fsge_pkg::V_1)) ?
                      fsge_pkg::V_1 : fsge_pkg::V_0);
    assign w_xnor  = w_ab_xz ? fsge_pkg::V_X :
                     (((w_a == fsge_pkg::V_1 && w_b == fsge_pkg::V_1) ||
                       (w_a == fsge_pkg::V_0 && w_b == fsge_pkg::V_0)) ?
                      fsge_pkg::V_1 : fsge_pkg::V_0);

    // Select the result by gate kind
    always_comb begin
        case (i_item.kind)
            fsge_pkg::K_NOT: begin
                o_gate_value = (w_a == fsge_pkg::V_0) ? fsge_pkg::V_1 :
                               (w_a == fsge_pkg::V_1) ? fsge_pkg::V_0 : fsge_pkg::V_X;
            end
            fsge_pkg::K_BUF: begin
                o_gate_value = (w_a == fsge_pkg::V_Z) ? fsge_pkg::V_X : w_a;
            end
            fsge_pkg::K_AND:    o_gate_value = w_and;
            fsge_pkg::K_OR:     o_gate_value = w_or;
            fsge_pkg::K_XOR:    o_gate_value = w_xor;
            fsge_pkg::K_NAND:   o_gate_value = invert_known(w_and);
            fsge_pkg::K_NOR:    o_gate_value = invert_known(w_or);
            fsge_pkg::K_XNOR:   o_gate_value = w_xnor;
            fsge_pkg::K_BUFIF0: begin
                o_gate_value = eval_tri(w_a, w_b, fsge_pkg::V_0, fsge_pkg::V_1, 1'b0);
            end
            fsge_pkg::K_BUFIF1: begin
                o_gate_value = eval_tri(w_a, w_b, fsge_pkg::V_1, fsge_pkg::V_0, 1'b0);
            end
            fsge_pkg::K_NOTIF0: begin
                o_gate_value = eval_tri(w_a, w_b, fsge_pkg::V_0, fsge_pkg::V_1, 1'b1);
            end
            fsge_pkg::K_NOTIF1: begin
                o_gate_value = eval_tri(w_a, w_b, fsge_pkg::V_1, fsge_pkg::V_0, 1'b1);
            end
            fsge_pkg::K_ASSIGN: o_gate_value = w_a;
            default:            o_gate_value = fsge_pkg::V_X;
        endcase
    end

endmodule

[rtl/four_state_gate_evaluator.sv]
`timescale 1ns / 1ps
// Path: input register, then gate evaluation, then result register.
// Throughput: one gate item per cycle, limited only by output back-pressure;
// the input register refills in the cycle its item moves to the result.
// Reset: synchronous, active low; clears both valid flags, no data is reset.
// ---------------------------------------------------------------------------
// four_state_gate_evaluator: six-valued primitive gate evaluator
// Evaluates one Verilog primitive gate per transfer in 0/1/X/Z/L/H logic and
// returns one result transfer per item.
// ---------------------------------------------------------------------------
module four_state_gate_evaluator #(
    parameter int INPUT_LANES = fsge_pkg::INPUT_LANES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: kind[3:0], input_count[7:4], in0[10:8], in1[13:11], in2[16:14],
    //        in3[19:17], in4[22:20], in5[25:23], in6[28:26], in7[31:29]
    input  logic [fsge_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: gate_value[2:0], zero fill [7:3]
    output logic [fsge_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    logic            w_advance;
    logic            w_in_valid;
    fsge_pkg::t_item w_item;
    fsge_pkg::t_val  w_gate_value;
    logic            r_out_valid;
    logic            n_out_valid;
    fsge_pkg::t_val  r_gate_value;
    logic            w_load;

    // Result register is free when empty or being drained
    assign w_advance = !r_out_valid || i_m_axis_tready;
    assign w_load    = w_in_valid && w_advance;

    fsge_in_stage u_in_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_advance       (w_advance),
        .o_valid         (w_in_valid),
        .o_item          (w_item)
    );

    fsge_eval #(
        .INPUT_LANES (INPUT_LANES)
    ) u_eval (
        .i_item       (w_item),
        .o_gate_value (w_gate_value)
    );

    // Hold the result until transferred, refill when the next item arrives
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_gate_value <= w_gate_value;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(fsge_pkg::M_TDATA_W - fsge_pkg::VAL_W){1'b0}}, r_gate_value};

endmodule
